// ----- rtl/jtpt_pkg.sv -----
`default_nettype none
package jtpt_pkg;

    typedef enum logic [3:0] {
        OP_OTHER = 4'd0,
        OP_LUI   = 4'd1,
        OP_ADDIU = 4'd2,
        OP_ADDU  = 4'd3,
        OP_MOVE  = 4'd4,
        OP_SW    = 4'd5,
        OP_LW    = 4'd6,
        OP_JR    = 4'd7,
        OP_FSTART = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_FOUND  = 2'd1,
        ST_MISALN = 2'd2,
        ST_HALTED = 2'd3
    } t_status;

    localparam logic [4:0] REG_GP = 5'd28;
    localparam logic [4:0] REG_SP = 5'd29;
    localparam logic [4:0] REG_RA = 5'd31;

    // Full tracking record of one register or stack slot
    typedef struct packed {
        logic [31:0] lui_val;
        logic [31:0] addiu_val;
        logic [4:0]  addend;
        logic [15:0] got_off;
        logic        v_lui;
        logic        v_addiu;
        logic        v_addend;
        logic        v_got;
        logic [31:0] addu_pc;
        logic [31:0] ld_target;
        logic [31:0] ld_pc;
        logic [31:0] ld_addu_pc;
        logic [4:0]  ld_addend;
        logic        v_loaded;
        logic        v_got_loaded;
    } t_track;

    // Write request toward the register file and stack
    typedef struct packed {
        logic        reg_we;
        logic [4:0]  reg_idx;
        logic        reg_we2;
        logic [4:0]  reg_idx2;
        logic        clear;
        logic        set_halt;
    } t_ctl;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/jtpt_core.sv -----
`default_nettype none
// Combinational decode of one item against the register records
module jtpt_core (
    input  var logic [3:0]           i_op,
    input  var logic [4:0]           i_rd,
    input  var logic [4:0]           i_rs,
    input  var logic [4:0]           i_rt,
    input  var logic [15:0]          i_imm,
    input  var logic [31:0]          i_pc,
    input  var logic                 i_wd,
    input  var logic                 i_wt,
    input  var logic                 i_got_present,
    input  var logic                 i_halted,
    input  var jtpt_pkg::t_track     i_a,
    input  var jtpt_pkg::t_track     i_b,
    input  var logic                 i_slot_ok,
    input  var jtpt_pkg::t_track     i_slot,
    output jtpt_pkg::t_ctl           o_ctl,
    output jtpt_pkg::t_track         o_wr,
    output logic                     o_slot_we,
    output jtpt_pkg::t_status        o_status,
    output logic [31:0]              o_table_address,
    output logic [4:0]               o_index_reg,
    output logic [31:0]              o_load_address,
    output logic [31:0]              o_add_address,
    output logic                     o_uses_got,
    output logic [15:0]              o_got_entry_offset
);
    always_comb begin
        jtpt_pkg::t_track t;
        logic sp_base;
        logic misal;
        logic nz;
        t = '0;
        o_ctl = '0;
        o_slot_we = 1'b0;
        o_status = jtpt_pkg::ST_NONE;
        o_table_address = '0;
        o_index_reg = '0;
        o_load_address = '0;
        o_add_address = '0;
        o_uses_got = 1'b0;
        o_got_entry_offset = '0;
        sp_base = (i_rs == jtpt_pkg::REG_SP);
        misal = sp_base && (i_imm[1:0] != 2'b00);
        nz = (i_imm != 16'd0);
        if (i_op == jtpt_pkg::OP_FSTART) begin
            o_ctl.clear = 1'b1;
        end else if (i_halted) begin
            o_status = jtpt_pkg::ST_HALTED;
        end else begin
            case (i_op)
                jtpt_pkg::OP_LUI: begin
                    t.lui_val = {i_imm, 16'd0};
                    t.v_lui = 1'b1;
                    o_ctl.reg_we = 1'b1;
                    o_ctl.reg_idx = i_rt;
                end
                jtpt_pkg::OP_ADDIU: begin
                    if (!i_a.v_addiu) begin
                        t = i_a;
                        t.addiu_val = jtpt_pkg::sext16(i_imm);
                        t.v_addiu = 1'b1;
                    end
                    o_ctl.reg_we = 1'b1;
                    o_ctl.reg_idx = i_rt;
                end
                jtpt_pkg::OP_ADDU: begin
                    if (i_a.v_got != i_b.v_got) begin
                        t = i_a.v_got ? i_a : i_b;
                        t.v_addend = 1'b1;
                        t.addend = i_a.v_got ? i_rt : i_rs;
                        t.addu_pc = i_pc;
                    end else if ((i_rs == jtpt_pkg::REG_GP || i_rt == jtpt_pkg::REG_GP)
                                 && i_a.v_got_loaded != i_b.v_got_loaded) begin
                        t = i_a.v_got_loaded ? i_a : i_b;
                    end else if (i_a.v_lui != i_b.v_lui) begin
                        t = i_a.v_lui ? i_a : i_b;
                        t.v_addend = 1'b1;
                        t.addend = i_a.v_lui ? i_rt : i_rs;
                        t.addu_pc = i_pc;
                    end
                    o_ctl.reg_we = 1'b1;
                    o_ctl.reg_idx = i_rd;
                end
                jtpt_pkg::OP_MOVE: begin
                    if (i_rs == 5'd0) t = i_b;
                    else if (i_rt == 5'd0) t = i_a;
                    o_ctl.reg_we = 1'b1;
                    o_ctl.reg_idx = i_rd;
                end
                jtpt_pkg::OP_SW: begin
                    if (misal) begin
                        o_ctl.set_halt = 1'b1;
                        o_status = jtpt_pkg::ST_MISALN;
                    end else if (sp_base && i_slot_ok) begin
                        o_slot_we = 1'b1;
                    end
                end
                jtpt_pkg::OP_LW: begin
                    if (misal) begin
                        o_ctl.set_halt = 1'b1;
                        o_status = jtpt_pkg::ST_MISALN;
                    end else begin
                        if (sp_base) begin
                            if (i_slot_ok) t = i_slot;
                        end else if (i_a.v_lui && i_a.v_addend) begin
                            if (!(nz && i_a.v_addiu)) begin
                                t.v_loaded = 1'b1;
                                t.ld_pc = i_pc;
                                t.ld_target = i_a.lui_val
                                    + (nz ? jtpt_pkg::sext16(i_imm) : i_a.addiu_val);
                                t.ld_addend = i_a.addend;
                                t.ld_addu_pc = i_a.addu_pc;
                            end
                        end else if (i_a.v_got && i_a.v_addend) begin
                            t.v_got_loaded = 1'b1;
                            t.ld_pc = i_pc;
                            t.ld_target = {16'd0, i_imm};
                            t.ld_addend = i_a.addend;
                            t.ld_addu_pc = i_a.addu_pc;
                            t.got_off = i_a.got_off;
                        end else if (i_rs == jtpt_pkg::REG_GP && i_got_present) begin
                            t.got_off = i_imm;
                            t.v_got = 1'b1;
                        end
                        o_ctl.reg_we = 1'b1;
                        o_ctl.reg_idx = i_rt;
                    end
                end
                jtpt_pkg::OP_JR: begin
                    if (i_rs != jtpt_pkg::REG_RA && (i_a.v_loaded || i_a.v_got_loaded)) begin
                        o_status = jtpt_pkg::ST_FOUND;
                        o_table_address = i_a.ld_target;
                        o_index_reg = i_a.ld_addend;
                        o_load_address = i_a.ld_pc;
                        o_add_address = i_a.ld_addu_pc;
                        if (!i_a.v_loaded) begin
                            o_uses_got = 1'b1;
                            o_got_entry_offset = i_a.got_off;
                        end
                    end
                end
                default: begin
                    // Blank rd by writing an empty record; drop rt by clearing its valid bit
                    o_ctl.reg_we = i_wd;
                    o_ctl.reg_idx = i_rd;
                    o_ctl.reg_we2 = i_wt;
                    o_ctl.reg_idx2 = i_rt;
                end
            endcase
        end
        o_wr = t;
    end
endmodule
`default_nettype wire

// ----- rtl/jump_table_pattern_tracker.sv -----
`default_nettype none
// Channel   | Ports                                   | Handshake
// config    | i_cfg_we, i_cfg_data                    | written when i_cfg_we high
// item in   | i_start, i_operation .. i_writes_second | taken when i_start && !o_busy
// result    | o_done, o_status .. o_got_entry_offset  | one cycle, o_done strobe
//
// Per item, the accept edge loads the input register and reads the
// stack slot memory; the next edge updates the records and loads the result,
// so o_done is high in the cycle after that. A new item can be taken every
// cycle: a stack write is forwarded to a read of the same slot at that edge.
// Reset clears config, halt and valid bits; payload reads as zero through them.
// o_busy stays low. The receiver cannot stall the result.
module jump_table_pattern_tracker #(
    parameter int STACK_SLOTS = 64
) (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var logic        i_cfg_we,
    input  var logic        i_cfg_data,
    input  var logic        i_start,
    output logic            o_busy,
    input  var logic [3:0]  i_operation,
    input  var logic [4:0]  i_dest_reg,
    input  var logic [4:0]  i_source_reg,
    input  var logic [4:0]  i_second_reg,
    input  var logic [15:0] i_immediate,
    input  var logic [31:0] i_instr_address,
    input  var logic        i_writes_dest,
    input  var logic        i_writes_second,
    output logic            o_done,
    output logic [1:0]      o_status,
    output logic [31:0]     o_table_address,
    output logic [4:0]      o_index_reg,
    output logic [31:0]     o_load_address,
    output logic [31:0]     o_add_address,
    output logic [31:0]     o_jump_address,
    output logic            o_uses_got,
    output logic [15:0]     o_got_entry_offset
);
    localparam int SW = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;

    logic r_got_present;
    logic r_halted;
    jtpt_pkg::t_track r_regs [32];
    logic [31:0] r_reg_v, n_reg_v;
    jtpt_pkg::t_track r_stack [STACK_SLOTS];
    logic [STACK_SLOTS-1:0] r_slot_v;
    jtpt_pkg::t_track r_slot_rd;

    // Input register
    logic        r_vld;
    logic [3:0]  r_op;
    logic [4:0]  r_rd, r_rs, r_rt;
    logic [15:0] r_imm;
    logic [31:0] r_pc;
    logic        r_wd, r_wt;

    jtpt_pkg::t_track a_rec, b_rec, slot_rec, wr_rec;
    jtpt_pkg::t_ctl ctl;
    jtpt_pkg::t_status status;
    logic slot_we, slot_ok, acc, upd;
    logic [13:0] slot_full;
    logic [SW-1:0] slot_idx, in_slot_idx;
    logic [31:0] tab_a, ld_a, add_a;
    logic [4:0] idx_r;
    logic ug;
    logic [15:0] goff;

    assign acc = i_start && !o_busy;
    assign o_busy = 1'b0;
    assign upd = r_vld && !ctl.clear;
    assign a_rec = r_reg_v[r_rs] ? r_regs[r_rs] : '0;
    assign b_rec = r_reg_v[r_rt] ? r_regs[r_rt] : '0;
    assign slot_full = r_imm[15:2];
    assign slot_idx = SW'(slot_full);
    assign in_slot_idx = SW'(i_immediate[15:2]);
    assign slot_ok = !r_imm[15] && ({18'd0, slot_full} < 32'(STACK_SLOTS));
    assign slot_rec = r_slot_v[slot_idx] ? r_slot_rd : '0;

    jtpt_core u_core (
        .i_op(r_op), .i_rd(r_rd), .i_rs(r_rs),
        .i_rt(r_rt), .i_imm(r_imm), .i_pc(r_pc),
        .i_wd(r_wd), .i_wt(r_wt),
        .i_got_present(r_got_present), .i_halted(r_halted),
        .i_a(a_rec), .i_b(b_rec), .i_slot_ok(slot_ok), .i_slot(slot_rec),
        .o_ctl(ctl), .o_wr(wr_rec), .o_slot_we(slot_we), .o_status(status),
        .o_table_address(tab_a), .o_index_reg(idx_r), .o_load_address(ld_a),
        .o_add_address(add_a), .o_uses_got(ug), .o_got_entry_offset(goff)
    );

    // Next register valid bits: set on a record write, drop on a blanked rt
    always_comb begin
        n_reg_v = r_reg_v;
        if (ctl.reg_we) n_reg_v[ctl.reg_idx] = 1'b1;
        if (ctl.reg_we2) n_reg_v[ctl.reg_idx2] = 1'b0;
    end

    // Control state: config, halt, valid bits, stage flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_got_present <= 1'b0;
            r_halted <= 1'b0;
            r_reg_v <= '0;
            r_slot_v <= '0;
            r_vld <= 1'b0;
            o_done <= 1'b0;
        end else begin
            if (i_cfg_we) r_got_present <= i_cfg_data;
            r_vld <= acc;
            o_done <= r_vld;
            if (r_vld) begin
                if (ctl.clear) begin
                    r_halted <= 1'b0;
                    r_reg_v <= '0;
                    r_slot_v <= '0;
                end else begin
                    if (ctl.set_halt) r_halted <= 1'b1;
                    r_reg_v <= n_reg_v;
                    if (slot_we) r_slot_v[slot_idx] <= 1'b1;
                end
            end
        end
    end

    // Payload: input register, slot read, records, stack slots, result register
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op <= i_operation;
            r_rd <= i_dest_reg;
            r_rs <= i_source_reg;
            r_rt <= i_second_reg;
            r_imm <= i_immediate;
            r_pc <= i_instr_address;
            r_wd <= i_writes_dest;
            r_wt <= i_writes_second;
            // Forward a store to the same slot made at this edge
            r_slot_rd <= (upd && slot_we && slot_idx == in_slot_idx) ? b_rec
                                                                     : r_stack[in_slot_idx];
        end
        if (upd) begin
            if (ctl.reg_we) r_regs[ctl.reg_idx] <= wr_rec;
            if (slot_we) r_stack[slot_idx] <= b_rec;
        end
        if (r_vld) begin
            o_status <= status;
            o_table_address <= tab_a;
            o_index_reg <= idx_r;
            o_load_address <= ld_a;
            o_add_address <= add_a;
            o_jump_address <= (status == jtpt_pkg::ST_FOUND) ? r_pc : 32'd0;
            o_uses_got <= ug;
            o_got_entry_offset <= goff;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/jtpt_checker.sv -----
`default_nettype none
module jtpt_checker (
    input var logic        i_clk,
    input var logic        i_rst_n,
    input var logic        i_start,
    input var logic        o_busy,
    input var logic        o_done,
    input var logic [1:0]  o_status,
    input var logic [31:0] o_table_address,
    input var logic        o_uses_got,
    input var logic [15:0] o_got_entry_offset
);
    // A result follows every accepted item, through the r_vld and then the o_done register
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##2 o_done) else $error("missing result");
    a_nodone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |-> ##2 !o_done) else $error("spurious result");
    // Fields stay zero unless a table was found
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != jtpt_pkg::ST_FOUND)
            |-> (o_table_address == 32'd0 && !o_uses_got))
        else $error("nonzero fields");
    a_got: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_uses_got) |-> o_got_entry_offset == 16'd0)
        else $error("got offset without got");
endmodule

bind jump_table_pattern_tracker jtpt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_status(o_status), .o_table_address(o_table_address),
    .o_uses_got(o_uses_got), .o_got_entry_offset(o_got_entry_offset)
);
`default_nettype wire
